[rtl/spq_pkg.sv]
package spq_pkg;

   localparam int KEY_W = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cell_op_type              op;
      logic signed [KEY_W-1:0]  key;
   } cell_ctl_type;

   // where a cell sits relative to the fill count
   typedef struct packed {
      logic live;      // holds a key
      logic fill_pos;  // first free slot
      logic tail;      // last held key
   } cell_pos_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

[rtl/spq_cell.sv]
module spq_cell
   import spq_pkg::*;
(
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  cell_pos_type            pos,
   input  logic signed [KEY_W-1:0] left_entry,
   input  logic                    left_gt,
   input  logic signed [KEY_W-1:0] right_entry,
   input  logic signed [KEY_W-1:0] head_entry,
   output logic signed [KEY_W-1:0] entry,
   output logic                    gt
);

   logic signed [KEY_W-1:0] entry_ff;
   logic signed [KEY_W-1:0] entry_in;

   assign entry = entry_ff;
   assign gt    = pos.live && (entry_ff > ctl.key);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            // keys above the new one move one slot right; equal keys stay ahead
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt || pos.fill_pos) begin
               entry_in = ctl.key;
            end
         end
         CELL_DELETE: begin
            entry_in = right_entry;
         end
         CELL_ROTATE: begin
            if (pos.tail) begin
               entry_in = head_entry;
            end else begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/sorted_priority_queue_top.sv]
// Sorted priority queue of signed 32-bit keys, smallest at the head.
// Input channel req_*: tuser carries the command (insert, delete minimum,
// read out all), tdata the key for an insert. Result channel rsp_*: tuser
// carries the status (ok, full, empty), tdata the removed or read-out key
// (zero otherwise), tlast marks the final beat of a command.
// The keys live in a row of DEPTH cells; each cell compares its key with the
// incoming one and takes its own, its neighbor's or the new key, so an insert
// or a delete updates every cell together and its single result beat is
// registered in the cycle after acceptance. Insert and delete sustain one
// command per cycle while the receiver takes every beat.
// A read-out rotates the held keys once around the live part of the row,
// one beat per cycle from the head while the receiver takes every beat; the
// read state is entered on acceptance and registers each beat from there,
// req_tready stays low until the last beat is registered; a read-out of an
// empty queue gives a single empty beat. The rotation leaves the order unchanged.
// Reset empties the queue; key storage is not cleared.
// A stalled result beat holds in the output register; req_tready stays low
// until it is taken or during a read-out.
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [KEY_W-1:0]  req_tdata,   // [31:0] value
   input  logic [1:0]        req_tuser,   // [1:0] command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [KEY_W-1:0]  rsp_tdata,   // [31:0] data
   output logic [1:0]        rsp_tuser,   // [1:0] status
   output logic              rsp_tlast
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_data_ff, rsp_data_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_ctl_type       ctl;
   logic               out_free;
   logic               accept;
   logic [CNT_W-1:0]   rd_next;
   cmd_type            cmd;

   logic signed [KEY_W-1:0] entry_w [DEPTH];
   logic                    gt_w    [DEPTH];

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_pos_type            pos;
      logic signed [KEY_W-1:0] left_e;
      logic                    left_g;
      logic signed [KEY_W-1:0] right_e;

      assign pos.live     = CNT_W'(i) < fill_ff;
      assign pos.fill_pos = CNT_W'(i) == fill_ff;
      assign pos.tail     = CNT_W'(i + 1) == fill_ff;

      if (i == 0) begin : g_first
         assign left_e = entry_w[0];
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = entry_w[i-1];
         assign left_g = gt_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = entry_w[i];
      end else begin : g_inner
         assign right_e = entry_w[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (pos),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .head_entry  (entry_w[0]),
         .entry       (entry_w[i]),
         .gt          (gt_w[i])
      );
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign rd_next    = rd_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = CELL_HOLD;
      ctl.key       = req_tdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (fill_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_OK;
                        ctl.op        = CELL_INSERT;
                        fill_in       = fill_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        rsp_status_in = STAT_OK;
                        rsp_data_in   = entry_w[0];
                        ctl.op        = CELL_DELETE;
                        fill_in       = fill_ff - CNT_W'(1);
                     end
                  end
                  CMD_READ: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        rd_in    = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     // unused code: dropped without a result
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = entry_w[0];
               rsp_last_in   = rd_next == fill_ff;
               ctl.op        = CELL_ROTATE;
               rd_in         = rd_next;
               if (rd_next == fill_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_read_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_ff < fill_ff))
      else $error("read-out index past fill count");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_INSERT && fill_ff != CNT_W'(DEPTH))
      |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("insert did not grow the queue");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == '0 && rsp_tlast))
      else $error("error beat with data or without last");

   a_read_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && out_free && rd_next == fill_ff) |=> (state_ff == ST_IDLE))
      else $error("read-out did not end on its last beat");
`endif

endmodule
